// File: rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define MPFRT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// antecedent on one edge, consequent on the next
`define MPFRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/mpfrt_pkg.sv
package mpfrt_pkg;

  localparam int PIPE_COUNT       = 6;
  localparam int FRAME_MAX        = 32;
  localparam int CONTENT_CAPACITY = 1024;

  localparam int PIPE_W = 3;
  localparam int SIZE_W = 11;
  localparam int LEN_W  = 6;
  localparam int TMO_W  = 16;
  localparam int TIME_W = 32;

  typedef enum logic [2:0] {
    MODE_INACTIVE  = 3'd0,
    MODE_IDLE      = 3'd1,
    MODE_RECEIVING = 3'd2,
    MODE_TIMEDOUT  = 3'd3,
    MODE_RECEIVED  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    RC_NONE     = 3'd0,
    RC_SKIPPED  = 3'd1,
    RC_PARTIAL  = 3'd2,
    RC_COMPLETE = 3'd3,
    RC_ACCEPTED = 3'd4,
    RC_REFUSED  = 3'd5
  } rc_t;

  typedef enum logic [2:0] {
    REQ_FRAME   = 3'd0,
    REQ_OPEN    = 3'd1,
    REQ_CLOSE   = 3'd2,
    REQ_CONSUME = 3'd3,
    REQ_TMO     = 3'd4,
    REQ_QUERY   = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    CONT_NONE = 2'd0,
    CONT_DATA = 2'd1,
    CONT_CMD  = 2'd2
  } cont_t;

  typedef enum logic [1:0] {
    SIG_UNKNOWN = 2'd0,
    SIG_GOOD    = 2'd1,
    SIG_BAD     = 2'd2
  } sig_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    req_t              req_type;
    logic [PIPE_W-1:0] pipe;
    logic [LEN_W-1:0]  psize;
    logic [LEN_W-1:0]  hsize;
    logic [2:0]        flags;
    logic [7:0]        sid;
    logic [7:0]        snum;
    logic [1:0]        sigb;
    logic [TIME_W-1:0] now;
    logic [SIZE_W-1:0] room;
  } req_s_t;

  typedef struct packed {
    rc_t               rc;
    logic [SIZE_W-1:0] wr_off;
    logic [LEN_W-1:0]  body_len;
    logic [1:0]        any_content;
    logic [PIPE_W-1:0] ready_pipe;
    logic              ready_found;
    cont_t             pipe_content;
    logic [SIZE_W-1:0] content_size;
    logic [PIPE_W-1:0] tmo_pipe;
    logic              tmo_found;
  } carry_t;

endpackage

// File: rtl/mpfrt_cfg.sv
module mpfrt_cfg import mpfrt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [SIZE_W-1:0] size_lim,
  output logic [TMO_W-1:0]  tmo_ms
);

  logic [SIZE_W-1:0] mds_r;
  logic [TMO_W-1:0]  tmo_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mds_r <= SIZE_W'(1024);
      tmo_r <= TMO_W'(1000);
    end else if (wr_en) begin
      if (paddr[2]) begin
        tmo_r <= pwdata[TMO_W-1:0];
      end else begin
        mds_r <= pwdata[SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[1:0] != 2'd0) begin
      prdata = 32'd0;
    end else if (paddr[2]) begin
      prdata = 32'(tmo_r);
    end else begin
      prdata = 32'(mds_r);
    end
  end

  assign size_lim = (32'(mds_r) > CONTENT_CAPACITY) ? SIZE_W'(CONTENT_CAPACITY) : mds_r;
  assign tmo_ms   = tmo_r;

endmodule

// File: rtl/mpfrt_cell.sv
module mpfrt_cell import mpfrt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PIPE_W-1:0] idx,
  input  req_s_t            req,
  input  logic [SIZE_W-1:0] lim,
  input  logic [TMO_W-1:0]  tmo,
  input  logic              tok_in,
  input  carry_t            carry_in,
  output logic              tok_out,
  output carry_t            carry_out
);

  mode_t             mode_r, mode_nxt;
  logic [7:0]        sid_r, sid_nxt;
  logic [7:0]        lsn_r, lsn_nxt;
  logic [SIZE_W-1:0] held_r, held_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic              cmd_r, cmd_nxt;
  logic              tok_r;
  carry_t            carry_r, carry_nxt;

  logic              sel;
  logic              frame_ok;
  logic [LEN_W-1:0]  body;
  logic [SIZE_W:0]   sum;
  logic [TIME_W-1:0] elapsed;

  assign sel      = (req.pipe == idx);
  assign frame_ok = (req.psize != '0) && (32'(req.psize) < FRAME_MAX) &&
                    (req.hsize != '0) && (req.hsize <= req.psize);
  assign body     = req.psize - req.hsize;
  assign sum      = {1'b0, held_r} + (SIZE_W+1)'(body);
  assign elapsed  = req.now - time_r;

  always_comb begin
    mode_nxt  = mode_r;
    sid_nxt   = sid_r;
    lsn_nxt   = lsn_r;
    held_nxt  = held_r;
    time_nxt  = time_r;
    cmd_nxt   = cmd_r;
    carry_nxt = carry_in;
    case (req.req_type)
      REQ_FRAME: begin
        if (sel && frame_ok) begin
          carry_nxt.rc = RC_SKIPPED;
          case (mode_r) inside
            MODE_IDLE, MODE_TIMEDOUT: begin
              if (req.flags[0] && (SIZE_W'(body) <= lim)) begin
                sid_nxt                = req.sid;
                cmd_nxt                = req.flags[2];
                held_nxt               = SIZE_W'(body);
                lsn_nxt                = req.snum;
                time_nxt               = req.now;
                mode_nxt               = req.flags[1] ? MODE_RECEIVED : MODE_RECEIVING;
                carry_nxt.rc           = req.flags[1] ? RC_COMPLETE : RC_PARTIAL;
                carry_nxt.wr_off       = '0;
                carry_nxt.body_len     = body;
              end
            end
            MODE_RECEIVING: begin
              if ((req.sid == sid_r) && ({1'b0, req.snum} == {1'b0, lsn_r} + 9'd1) &&
                  (sum <= {1'b0, lim})) begin
                held_nxt               = sum[SIZE_W-1:0];
                lsn_nxt                = req.snum;
                time_nxt               = req.now;
                mode_nxt               = req.flags[1] ? MODE_RECEIVED : MODE_RECEIVING;
                carry_nxt.rc           = req.flags[1] ? RC_COMPLETE : RC_PARTIAL;
                carry_nxt.wr_off       = held_r;
                carry_nxt.body_len     = body;
              end
            end
            default: ;
          endcase
        end
      end
      REQ_OPEN: begin
        if (sel) begin
          if (mode_r != MODE_INACTIVE) begin
            carry_nxt.rc = RC_REFUSED;
          end else begin
            mode_nxt     = MODE_IDLE;
            carry_nxt.rc = RC_ACCEPTED;
          end
        end
      end
      REQ_CLOSE: begin
        if (sel) begin
          if (mode_r == MODE_INACTIVE) begin
            carry_nxt.rc = RC_REFUSED;
          end else begin
            mode_nxt     = MODE_INACTIVE;
            carry_nxt.rc = RC_ACCEPTED;
          end
        end
      end
      REQ_CONSUME: begin
        if (sel) begin
          if ((mode_r == MODE_RECEIVED) && (req.room >= held_r)) begin
            mode_nxt     = MODE_IDLE;
            carry_nxt.rc = RC_ACCEPTED;
          end else begin
            carry_nxt.rc = RC_REFUSED;
          end
        end
      end
      REQ_TMO: begin
        if (!carry_in.tmo_found && (mode_r == MODE_RECEIVING) &&
            (elapsed > TIME_W'(tmo))) begin
          mode_nxt           = MODE_TIMEDOUT;
          carry_nxt.tmo_found = 1'b1;
          carry_nxt.tmo_pipe  = idx;
        end
      end
      default: ;
    endcase

    // readiness from the updated record
    if (mode_nxt == MODE_RECEIVED) begin
      carry_nxt.any_content = carry_nxt.any_content | (cmd_nxt ? 2'b10 : 2'b01);
      if (!carry_nxt.ready_found) begin
        carry_nxt.ready_found = 1'b1;
        carry_nxt.ready_pipe  = idx;
      end
      if (sel) begin
        carry_nxt.pipe_content = cmd_nxt ? CONT_CMD : CONT_DATA;
        carry_nxt.content_size = held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_INACTIVE;
      held_r <= '0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (tok_in) begin
        mode_r <= mode_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      sid_r   <= sid_nxt;
      lsn_r   <= lsn_nxt;
      time_r  <= time_nxt;
      cmd_r   <= cmd_nxt;
      carry_r <= carry_nxt;
    end
  end

  assign tok_out   = tok_r;
  assign carry_out = carry_r;

endmodule

// File: rtl/multi_pipe_frame_reassembly_tracker.sv
// Reassembly tracker for up to six radio pipes, one record per pipe.
// in channel: one request item per handshake; in_tuser holds the request
// kind, in_tdata the pipe, frame sizes, flags, sequence fields, time and room.
// out channel: exactly one result item per request, result code on
// out_tuser, offsets, readiness and timeout report on out_tdata.
// A request is broadcast to a row of pipe cells and a token walks the row,
// one cell per cycle; each cell updates its own record and folds its
// readiness into the report handed to the next cell.
// One item is in work at a time, so a new item is taken only once the last
// has left the cell row and its result has moved into the output register.
// The length of the cell row sets the time from accept to out_tvalid.
// A finished result sits in the output register; while the receiver stalls
// the next item is still taken and walks the row, then waits in the last
// cell until the output register frees.
// Reset: all pipes inactive with zero byte counts, size limit 1024 bytes,
// timeout 1000 ms, no result pending.
`include "assert_macros.svh"

module multi_pipe_frame_reassembly_tracker import mpfrt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // pipe, payload_size, header_size, frame_flags, seq_id, seq_num,
  // signal_bits, now_ms, buffer_room
  input  logic [79:0] in_tdata,
  // req_type
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // write_offset, body_len, any_content, first_ready_pipe, ready_found,
  // pipe_content, content_size, timed_out_pipe, timeout_found, signal_level
  output logic [47:0] out_tdata,
  // result_code
  output logic [2:0]  out_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_t            state_r, state_nxt;
  req_s_t            req_r;
  logic              launch_r;
  logic              out_valid_r;
  carry_t            out_c_r;
  rc_t               out_rc_r;
  sig_t              out_sig_r;

  logic [SIZE_W-1:0] size_lim;
  logic [TMO_W-1:0]  tmo_ms;
  logic [PIPE_COUNT-1:0] tok;
  carry_t            carry [PIPE_COUNT];
  logic [PIPE_COUNT:0] tok_all;

  logic              accept;
  logic              tail;
  logic              out_free;
  logic              load;
  logic              pipe_bad;
  logic              pipe_req;
  logic              psize_ok;
  rc_t               rc_fin;
  sig_t              sig_fin;

  mpfrt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .size_lim (size_lim),
    .tmo_ms   (tmo_ms)
  );

  for (genvar i = 0; i < PIPE_COUNT; i++) begin : g_cell
    logic   tin;
    carry_t cin;
    if (i == 0) begin : g_head
      assign tin = launch_r;
      assign cin = '0;
    end else begin : g_link
      assign tin = tok[i-1];
      assign cin = carry[i-1];
    end
    mpfrt_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (PIPE_W'(i)),
      .req       (req_r),
      .lim       (size_lim),
      .tmo       (tmo_ms),
      .tok_in    (tin),
      .carry_in  (cin),
      .tok_out   (tok[i]),
      .carry_out (carry[i])
    );
  end

  assign accept   = in_tvalid && in_tready;
  assign tail     = tok[PIPE_COUNT-1];
  assign out_free = !out_valid_r || out_tready;
  assign tok_all  = {tok, launch_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_RUN;
      S_RUN: begin
        if (tail) state_nxt = out_free ? S_IDLE : S_DONE;
      end
      S_DONE: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (state_r == S_IDLE);
    load      = ((state_r == S_RUN && tail) || state_r == S_DONE) && out_free;
  end

  assign pipe_bad = 32'(req_r.pipe) >= PIPE_COUNT;
  assign pipe_req = (req_r.req_type == REQ_FRAME) || (req_r.req_type == REQ_OPEN) ||
                    (req_r.req_type == REQ_CLOSE) || (req_r.req_type == REQ_CONSUME) ||
                    (req_r.req_type == REQ_QUERY);
  assign psize_ok = (req_r.psize != '0) && (32'(req_r.psize) < FRAME_MAX);
  assign rc_fin   = (pipe_req && pipe_bad) ? RC_REFUSED : carry[PIPE_COUNT-1].rc;

  always_comb begin
    sig_fin = SIG_UNKNOWN;
    if (req_r.req_type == REQ_FRAME && !pipe_bad && psize_ok) begin
      if (req_r.sigb[0]) begin
        sig_fin = SIG_UNKNOWN;
      end else if (req_r.sigb[1]) begin
        sig_fin = SIG_BAD;
      end else begin
        sig_fin = SIG_GOOD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      launch_r <= accept;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.req_type <= req_t'(in_tuser);
      req_r.pipe     <= in_tdata[2:0];
      req_r.psize    <= in_tdata[8:3];
      req_r.hsize    <= in_tdata[14:9];
      req_r.flags    <= in_tdata[17:15];
      req_r.sid      <= in_tdata[25:18];
      req_r.snum     <= in_tdata[33:26];
      req_r.sigb     <= in_tdata[35:34];
      req_r.now      <= in_tdata[67:36];
      req_r.room     <= in_tdata[78:68];
    end
    if (load) begin
      out_c_r   <= carry[PIPE_COUNT-1];
      out_rc_r  <= rc_fin;
      out_sig_r <= sig_fin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_rc_r;
  assign out_tdata  = {6'd0, out_sig_r, out_c_r.tmo_found, out_c_r.tmo_pipe,
                       out_c_r.content_size, out_c_r.pipe_content, out_c_r.ready_found,
                       out_c_r.ready_pipe, out_c_r.any_content, out_c_r.body_len,
                       out_c_r.wr_off};

  `MPFRT_ASSERT(a_tok_single, $onehot0(tok_all))
  `MPFRT_ASSERT(a_tok_in_run, (|tok_all) |-> (state_r == S_RUN))
  `MPFRT_ASSERT_NEXT(a_accept_launch, accept, (state_r == S_RUN) && launch_r)
  `MPFRT_ASSERT_NEXT(a_load_shows, load, out_tvalid)

endmodule
